@@ sv/tpss_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tpss_pkg
// Shared types and codes of the tiered page scan selector.
// ---------------------------------------------------------------------------
package tpss_pkg;

  localparam int unsigned ADDR_W        = 48;
  localparam int unsigned OWNER_W       = 22;
  localparam int unsigned CNT_W         = 6;
  localparam int unsigned MODE_W        = 3;
  localparam int unsigned IN_DATA_W     = 80;
  localparam int unsigned OUT_DATA_W    = 80;
  localparam int unsigned MAX_SELECT_DF = 32;

  typedef enum logic [MODE_W-1:0] {
    MODE_FAST      = 3'd0,
    MODE_SLOW_FORCE = 3'd1,
    MODE_SLOW_INT  = 3'd2,
    MODE_SLOW_WR   = 3'd3,
    MODE_CLEAR     = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    FUNC_START  = 2'd0,
    FUNC_PAGE   = 2'd1,
    FUNC_FINISH = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    STAT_NONE  = 2'd0,
    STAT_MET   = 2'd1,
    STAT_SHORT = 2'd2
  } status_e;

  typedef enum logic {
    REG_SCAN_MODE  = 1'b0,
    REG_PAGE_QUOTA = 1'b1
  } reg_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_RD   = 2'd1,
    ST_WR   = 2'd2,
    ST_STAT = 2'd3
  } state_e;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [OWNER_W-1:0] owner;
  } entry_t;

  // Decision for one page entry
  typedef struct packed {
    logic selected;
    logic backed_up;
    logic clear_bits;
    logic quota_reached;
    logic save_fast;
    logic save_slow;
  } page_dec_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [OWNER_W-1:0] owner;
    logic               selected;
    logic               backed_up;
    logic               clear_bits;
    logic               quota_reached;
    logic [1:0]         scan_status;
    logic               last;
  } result_t;

endpackage
`default_nettype wire

@@ sv/tpss_backup_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tpss_backup_mem
// Backup page store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module tpss_backup_mem #(
  parameter int unsigned DEPTH = tpss_pkg::MAX_SELECT_DF,
  parameter int unsigned IDX_W = 5
) (
  input  wire logic                clk_i,
  input  wire logic                we_i,
  input  wire logic [IDX_W-1:0]    waddr_i,
  input  wire tpss_pkg::entry_t    wdata_i,
  input  wire logic                re_i,
  input  wire logic [IDX_W-1:0]    raddr_i,
  output tpss_pkg::entry_t         rdata_o
);
  import tpss_pkg::*;

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ sv/tpss_page_eval.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tpss_page_eval
// Classifies one page entry: select, back up, clear bits or quota stop.
// ---------------------------------------------------------------------------
module tpss_page_eval #(
  parameter int unsigned MAX_SELECT = tpss_pkg::MAX_SELECT_DF
) (
  input  wire logic [tpss_pkg::MODE_W-1:0] scan_mode_i,
  input  wire logic [tpss_pkg::CNT_W-1:0]  quota_i,
  input  wire logic [tpss_pkg::CNT_W-1:0]  found_i,
  input  wire logic [tpss_pkg::CNT_W-1:0]  bcount_i,
  input  wire logic                        is_present_i,
  input  wire logic                        is_writable_i,
  input  wire logic                        is_referenced_i,
  input  wire logic                        is_dirty_i,
  input  wire logic                        on_target_tier_i,
  output tpss_pkg::page_dec_t              dec_o
);
  import tpss_pkg::*;

  localparam logic [CNT_W-1:0] MaxSel = CNT_W'(MAX_SELECT);

  logic ok;
  logic want_sel;
  logic want_bak;
  logic want_clr;
  logic room;

  assign ok = is_present_i & is_writable_i & on_target_tier_i;
  // found < quota on this path, so the room compare cannot wrap
  assign room = ({1'b0, bcount_i} + {1'b0, found_i} < {1'b0, quota_i}) && (bcount_i < MaxSel);

  always_comb begin
    want_sel = 1'b0;
    want_bak = 1'b0;
    want_clr = 1'b0;
    case (scan_mode_i)
      MODE_FAST: begin
        if (!is_referenced_i) begin
          want_sel = 1'b1;
        end else begin
          want_bak = !is_dirty_i;
          want_clr = 1'b1;
        end
      end
      MODE_SLOW_FORCE: begin
        if (is_referenced_i && is_dirty_i) begin
          want_sel = 1'b1;
        end else begin
          want_bak = 1'b1;
          want_clr = 1'b1;
        end
      end
      MODE_SLOW_INT: begin
        want_sel = is_referenced_i & is_dirty_i;
        want_bak = is_referenced_i & !is_dirty_i;
      end
      MODE_SLOW_WR: begin
        want_sel = is_dirty_i & is_referenced_i;
        want_bak = is_dirty_i & !is_referenced_i;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    dec_o = '0;
    if (scan_mode_i == MODE_CLEAR) begin
      dec_o.clear_bits = ok;
    end else if (scan_mode_i < MODE_CLEAR) begin
      if (found_i >= quota_i) begin
        dec_o.quota_reached = 1'b1;
        dec_o.save_fast     = (scan_mode_i == MODE_FAST);
        dec_o.save_slow     = (scan_mode_i != MODE_FAST);
      end else if (ok) begin
        dec_o.selected   = want_sel;
        dec_o.backed_up  = !want_sel & want_bak & room;
        dec_o.clear_bits = want_clr;
      end
    end
  end

endmodule
`default_nettype wire

@@ sv/tiered_page_scan_selector_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// A page entry's result is registered and sits in the output register in the cycle after its transfer.
// Throughput: one page entry per cycle while idle and the output register is free; start gives no result.
// Finish (fast and slow modes): each backup page drained takes a memory read, then an
// output load; then a check and the status result follow; input is held off meanwhile.
// Reset clears configuration, counts, resume cursors and the output register;
// backup store contents stay undefined until written, with no clearing pass.
// ---------------------------------------------------------------------------
// tiered_page_scan_selector_unit
// Picks pages for tier migration from a stream of page entries, with a
// bounded backup store drained on finish.
// ---------------------------------------------------------------------------
module tiered_page_scan_selector_unit #(
  parameter int unsigned MAX_SELECT = tpss_pkg::MAX_SELECT_DF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // APB configuration
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [2:0]                         paddr,
  input  wire logic [31:0]                        pwdata,
  output logic [31:0]                             prdata,
  output logic                                    pready,
  // input stream
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // tdata: page_addr[47:0], owner_id[69:48], is_present[70], is_writable[71],
  //        is_referenced[72], is_dirty[73], on_target_tier[74], zero[79:75]
  input  wire logic [tpss_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // tuser: func[1:0]
  input  wire logic [1:0]                         s_axis_tuser,
  // output stream
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // tdata: out_addr[47:0], out_owner[69:48], selected[70], backed_up[71],
  //        clear_bits[72], quota_reached[73], scan_status[75:74], zero[79:76]
  output logic [tpss_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
  output logic                                    m_axis_tlast
);
  import tpss_pkg::*;

  localparam int unsigned IdxW = (MAX_SELECT > 1) ? $clog2(MAX_SELECT) : 1;
  localparam logic [CNT_W-1:0] MaxSel = CNT_W'(MAX_SELECT);

  state_e            state_q, state_d;
  logic [MODE_W-1:0] mode_q;
  logic [CNT_W-1:0]  quota_q;
  logic [CNT_W-1:0]  found_q, found_d;
  logic [CNT_W-1:0]  bcount_q, bcount_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [ADDR_W-1:0] fast_q, fast_d;
  logic [ADDR_W-1:0] slow_q, slow_d;
  logic              ovalid_q, ovalid_d;
  result_t           out_q, out_d;

  logic              cfg_wr;
  logic              s_fire;
  logic              out_free;
  logic [CNT_W-1:0]  eff_quota;
  entry_t            in_entry;
  entry_t            rd_entry;
  page_dec_t         dec;
  logic              mem_we;
  logic              mem_re;

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= '0;
      quota_q <= '0;
    end else if (cfg_wr) begin
      case (reg_e'(paddr[2]))
        REG_SCAN_MODE:  mode_q  <= pwdata[MODE_W-1:0];
        REG_PAGE_QUOTA: quota_q <= pwdata[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_e'(paddr[2]))
      REG_SCAN_MODE:  prdata = {{(32-MODE_W){1'b0}}, mode_q};
      REG_PAGE_QUOTA: prdata = {{(32-CNT_W){1'b0}}, quota_q};
      default:        prdata = '0;
    endcase
  end

  assign eff_quota = (quota_q < MaxSel) ? quota_q : MaxSel;

  assign out_free      = !ovalid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  assign in_entry.addr  = s_axis_tdata[ADDR_W-1:0];
  assign in_entry.owner = s_axis_tdata[ADDR_W+OWNER_W-1:ADDR_W];

  tpss_page_eval #(
    .MAX_SELECT(MAX_SELECT)
  ) u_eval (
    .scan_mode_i     (mode_q),
    .quota_i         (eff_quota),
    .found_i         (found_q),
    .bcount_i        (bcount_q),
    .is_present_i    (s_axis_tdata[70]),
    .is_writable_i   (s_axis_tdata[71]),
    .is_referenced_i (s_axis_tdata[72]),
    .is_dirty_i      (s_axis_tdata[73]),
    .on_target_tier_i(s_axis_tdata[74]),
    .dec_o           (dec)
  );

  assign mem_we = s_fire && (func_e'(s_axis_tuser) == FUNC_PAGE) && dec.backed_up;

  tpss_backup_mem #(
    .DEPTH(MAX_SELECT),
    .IDX_W(IdxW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(bcount_q[IdxW-1:0]),
    .wdata_i(in_entry),
    .re_i   (mem_re),
    .raddr_i(idx_q[IdxW-1:0]),
    .rdata_o(rd_entry)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      found_q  <= '0;
      bcount_q <= '0;
      idx_q    <= '0;
      fast_q   <= '0;
      slow_q   <= '0;
      ovalid_q <= 1'b0;
      out_q    <= '0;
    end else begin
      state_q  <= state_d;
      found_q  <= found_d;
      bcount_q <= bcount_d;
      idx_q    <= idx_d;
      fast_q   <= fast_d;
      slow_q   <= slow_d;
      ovalid_q <= ovalid_d;
      out_q    <= out_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    found_d  = found_q;
    bcount_d = bcount_q;
    idx_d    = idx_q;
    fast_d   = fast_q;
    slow_d   = slow_q;
    out_d    = out_q;
    ovalid_d = ovalid_q && !m_axis_tready;
    mem_re   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          case (func_e'(s_axis_tuser))
            FUNC_START: begin
              found_d  = '0;
              bcount_d = '0;
            end
            FUNC_PAGE: begin
              out_d.addr          = in_entry.addr;
              out_d.owner         = in_entry.owner;
              out_d.selected      = dec.selected;
              out_d.backed_up     = dec.backed_up;
              out_d.clear_bits    = dec.clear_bits;
              out_d.quota_reached = dec.quota_reached;
              out_d.scan_status   = dec.quota_reached ? STAT_MET : STAT_NONE;
              out_d.last          = 1'b1;
              ovalid_d            = 1'b1;
              if (dec.selected) begin
                found_d = found_q + 1'b1;
              end
              if (dec.backed_up) begin
                bcount_d = bcount_q + 1'b1;
              end
              if (dec.save_fast) begin
                fast_d = in_entry.addr;
              end
              if (dec.save_slow) begin
                slow_d = in_entry.addr;
              end
            end
            FUNC_FINISH: begin
              if (mode_q > MODE_SLOW_WR) begin
                out_d       = '0;
                out_d.last  = 1'b1;
                ovalid_d    = 1'b1;
              end else begin
                idx_d   = '0;
                state_d = ST_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_RD: begin
        if ((idx_q < bcount_q) && (found_q < eff_quota)) begin
          mem_re  = 1'b1;
          state_d = ST_WR;
        end else begin
          state_d = ST_STAT;
        end
      end
      ST_WR: begin
        // hold the read data until the output register frees up
        if (out_free) begin
          out_d          = '0;
          out_d.addr     = rd_entry.addr;
          out_d.owner    = rd_entry.owner;
          out_d.selected = 1'b1;
          ovalid_d       = 1'b1;
          found_d        = found_q + 1'b1;
          idx_d          = idx_q + 1'b1;
          state_d        = ST_RD;
        end
      end
      ST_STAT: begin
        if (out_free) begin
          out_d             = '0;
          out_d.addr        = (mode_q == MODE_FAST) ? fast_q : slow_q;
          out_d.scan_status = (found_q >= eff_quota) ? STAT_MET : STAT_SHORT;
          out_d.last        = 1'b1;
          ovalid_d          = 1'b1;
          bcount_d          = '0;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tlast  = out_q.last;
  assign m_axis_tdata  = {4'b0, out_q.scan_status, out_q.quota_reached, out_q.clear_bits,
                          out_q.backed_up, out_q.selected, out_q.owner, out_q.addr};

endmodule
`default_nettype wire

@@ verif/tiered_page_scan_selector_unit_test.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tiered_page_scan_selector_unit_test
// Streams page-entry, start and finish transfers into the selector under
// every scan mode and a range of quotas. Each accepted transfer runs through
// a local copy of the selection rules, and every output transfer is checked
// in order against the expected outcome. Both stream sides idle at random.
// ---------------------------------------------------------------------------
module tiered_page_scan_selector_unit_test;
  import tpss_pkg::*;

  localparam int unsigned MAX_SEL     = MAX_SELECT_DF;
  localparam int unsigned RAND_ITEMS  = 120;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam logic [1:0]  FUNC_UNUSED = 2'd3;
  localparam logic [2:0]  MODE_UNDEF  = 3'd5;
  localparam logic [ADDR_W-1:0]  ADDR_ONES  = '1;
  localparam logic [OWNER_W-1:0] OWNER_ONES = '1;

  typedef struct {
    logic [1:0]         func;
    logic [ADDR_W-1:0]  addr;
    logic [OWNER_W-1:0] owner;
    logic               present;
    logic               writable;
    logic               young;
    logic               dirty;
    logic               on_tier;
  } page_item_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // tdata: page_addr, owner_id, is_present, is_writable, is_referenced,
  //        is_dirty, on_target_tier, zero fill
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  // tuser: func
  logic [1:0]            s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // tdata: out_addr, out_owner, selected, backed_up, clear_bits,
  //        quota_reached, scan_status, zero fill
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;

  tiered_page_scan_selector_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Selector state as the block should hold it
  logic [2:0]         cfg_mode   = '0;
  logic [5:0]         cfg_quota  = '0;
  logic [5:0]         found_cnt  = '0;
  logic [5:0]         backup_cnt = '0;
  logic [ADDR_W-1:0]  backup_addr  [MAX_SEL];
  logic [OWNER_W-1:0] backup_owner [MAX_SEL];
  logic [ADDR_W-1:0]  cursor_fast = '0;
  logic [ADDR_W-1:0]  cursor_slow = '0;

  page_item_t entry_q[$];
  result_t    outcome_q[$];
  page_item_t cur_entry;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt    = 0;
  int unsigned in_gap       = 0;
  int unsigned out_stall    = 0;
  bit          in_calm      = 0;
  bit          out_calm     = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [ADDR_W-1:0] rand_addr();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return ADDR_ONES;
      2: return ADDR_W'($urandom_range(0, 255)) << 12;
      default: return ADDR_W'({$urandom, $urandom});
    endcase
  endfunction

  function automatic logic [OWNER_W-1:0] rand_owner();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return OWNER_ONES;
      default: return OWNER_W'($urandom);
    endcase
  endfunction

  function automatic void add_result(input logic [ADDR_W-1:0] addr,
                                     input logic [OWNER_W-1:0] owner,
                                     input logic sel, input logic bak,
                                     input logic clr, input logic qr,
                                     input status_e status, input logic last);
    result_t r;
    r.addr          = addr;
    r.owner         = owner;
    r.selected      = sel;
    r.backed_up     = bak;
    r.clear_bits    = clr;
    r.quota_reached = qr;
    r.scan_status   = status;
    r.last          = last;
    outcome_q.push_back(r);
  endfunction

  // Apply one accepted transfer to the local state and queue its outcomes
  function automatic void derive_page_outcomes(input page_item_t it);
    logic [5:0] quota;
    logic       eligible;
    logic       sel;
    logic       bak;
    logic       clr;
    logic       want_backup;
    quota    = (cfg_quota < 6'(MAX_SEL)) ? cfg_quota : 6'(MAX_SEL);
    eligible = it.present && it.writable && it.on_tier;
    case (it.func)
      FUNC_START: begin
        found_cnt  = '0;
        backup_cnt = '0;
      end
      FUNC_PAGE: begin
        if (cfg_mode > MODE_CLEAR) begin
          add_result(it.addr, it.owner, 0, 0, 0, 0, STAT_NONE, 1);
        end else if (cfg_mode == MODE_CLEAR) begin
          add_result(it.addr, it.owner, 0, 0, eligible, 0, STAT_NONE, 1);
        end else if (found_cnt >= quota) begin
          // save the resume cursor of the scanned tier
          if (cfg_mode == MODE_FAST) cursor_fast = it.addr;
          else cursor_slow = it.addr;
          add_result(it.addr, it.owner, 0, 0, 0, 1, STAT_MET, 1);
        end else begin
          sel         = 0;
          bak         = 0;
          clr         = 0;
          want_backup = 0;
          if (eligible) begin
            case (cfg_mode)
              MODE_FAST: begin
                if (!it.young) begin
                  sel = 1;
                end else begin
                  want_backup = !it.dirty;
                  clr         = 1;
                end
              end
              MODE_SLOW_FORCE: begin
                if (it.young && it.dirty) begin
                  sel = 1;
                end else begin
                  want_backup = 1;
                  clr         = 1;
                end
              end
              MODE_SLOW_INT: begin
                if (it.young) begin
                  if (it.dirty) sel = 1;
                  else want_backup = 1;
                end
              end
              default: begin
                if (it.dirty) begin
                  if (it.young) sel = 1;
                  else want_backup = 1;
                end
              end
            endcase
            if (sel) begin
              found_cnt = found_cnt + 6'd1;
            end else if (want_backup && backup_cnt < quota - found_cnt) begin
              backup_addr[backup_cnt]  = it.addr;
              backup_owner[backup_cnt] = it.owner;
              backup_cnt = backup_cnt + 6'd1;
              bak = 1;
            end
          end
          add_result(it.addr, it.owner, sel, bak, clr, 0, STAT_NONE, 1);
        end
      end
      FUNC_FINISH: begin
        if (cfg_mode > MODE_SLOW_WR) begin
          add_result('0, '0, 0, 0, 0, 0, STAT_NONE, 1);
        end else begin
          // top up from the backup store while below quota
          for (int i = 0; i < backup_cnt && found_cnt < quota; i++) begin
            add_result(backup_addr[i], backup_owner[i], 1, 0, 0, 0, STAT_NONE, 0);
            found_cnt = found_cnt + 6'd1;
          end
          backup_cnt = '0;
          add_result((cfg_mode == MODE_FAST) ? cursor_fast : cursor_slow, '0, 0, 0, 0, 0,
                     (found_cnt >= quota) ? STAT_MET : STAT_SHORT, 1);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic string fmt_result(input result_t r);
    return $sformatf("addr=%h owner=%h sel=%b bak=%b clr=%b qr=%b st=%0d last=%b",
                     r.addr, r.owner, r.selected, r.backed_up, r.clear_bits,
                     r.quota_reached, r.scan_status, r.last);
  endfunction

  // Input driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) derive_page_outcomes(cur_entry);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (in_gap != 0) begin
          in_gap = in_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (entry_q.size() != 0) begin
          cur_entry = entry_q.pop_front();
          s_axis_tdata  <= {5'b0, cur_entry.on_tier, cur_entry.dirty, cur_entry.young,
                            cur_entry.writable, cur_entry.present, cur_entry.owner,
                            cur_entry.addr};
          s_axis_tuser  <= cur_entry.func;
          s_axis_tvalid <= 1'b1;
          if ($urandom_range(0, 19) == 0) in_calm = !in_calm;
          in_gap = pick_gap(in_calm);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output monitor and ready generator
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.addr          = m_axis_tdata[47:0];
        got.owner         = m_axis_tdata[69:48];
        got.selected      = m_axis_tdata[70];
        got.backed_up     = m_axis_tdata[71];
        got.clear_bits    = m_axis_tdata[72];
        got.quota_reached = m_axis_tdata[73];
        got.scan_status   = m_axis_tdata[75:74];
        got.last          = m_axis_tlast;
        if (outcome_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("ERROR: result with nothing expected: %s", fmt_result(got));
        end else begin
          want = outcome_q.pop_front();
          if (got.addr !== want.addr || got.owner !== want.owner ||
              got.selected !== want.selected || got.backed_up !== want.backed_up ||
              got.clear_bits !== want.clear_bits ||
              got.quota_reached !== want.quota_reached ||
              got.scan_status !== want.scan_status || got.last !== want.last) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("ERROR: expected %s, got %s", fmt_result(want), fmt_result(got));
          end
        end
      end
      if (out_stall != 0) begin
        out_stall = out_stall - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 29) == 0) out_calm = !out_calm;
        if ($urandom_range(0, 2) == 0) out_stall = pick_gap(out_calm);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic add_item(input logic [1:0] func, input logic [ADDR_W-1:0] addr,
                          input logic [OWNER_W-1:0] owner, input logic present,
                          input logic writable, input logic young, input logic dirty,
                          input logic on_tier);
    page_item_t it;
    it.func     = func;
    it.addr     = addr;
    it.owner    = owner;
    it.present  = present;
    it.writable = writable;
    it.young    = young;
    it.dirty    = dirty;
    it.on_tier  = on_tier;
    entry_q.push_back(it);
  endtask

  // Hold until every expected result is in, then let the block settle
  task automatic wait_idle();
    while (entry_q.size() != 0 || s_axis_tvalid || outcome_q.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic apb_write(input reg_e idx, input int unsigned value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_SCAN_MODE) cfg_mode = 3'(value);
    else cfg_quota = 6'(value);
  endtask

  initial begin
    int unsigned rand_cnt;
    int unsigned n;
    logic [1:0]  f;
    logic        ok;
    rand_cnt = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // fast tier: select, ineligible variants, backup, clear only, quota met
    apb_write(REG_SCAN_MODE, MODE_FAST);
    apb_write(REG_PAGE_QUOTA, 2);
    add_item(FUNC_START, '0, '0, 0, 0, 0, 0, 0);
    add_item(FUNC_PAGE, ADDR_ONES, OWNER_ONES, 1, 1, 0, 0, 1);
    add_item(FUNC_PAGE, 48'h1000, 22'h1, 0, 1, 0, 0, 1);
    add_item(FUNC_PAGE, 48'h2000, 22'h2, 1, 0, 0, 0, 1);
    add_item(FUNC_PAGE, 48'h3000, 22'h3, 1, 1, 0, 0, 0);
    add_item(FUNC_PAGE, 48'h4000, 22'h4, 1, 1, 1, 0, 1);
    add_item(FUNC_PAGE, 48'h5000, 22'h5, 1, 1, 1, 1, 1);
    add_item(FUNC_PAGE, 48'h6000, 22'h6, 1, 1, 0, 1, 1);
    add_item(FUNC_PAGE, 48'h7000, 22'h7, 1, 1, 0, 0, 1);
    add_item(FUNC_FINISH, '0, '0, 0, 0, 0, 0, 0);
    wait_idle();
    // quota above the store size, ignored func, shortfall after top-up
    apb_write(REG_SCAN_MODE, MODE_SLOW_FORCE);
    apb_write(REG_PAGE_QUOTA, 63);
    add_item(FUNC_START, ADDR_ONES, OWNER_ONES, 1, 1, 1, 1, 1);
    add_item(FUNC_PAGE, 48'h8000, 22'h8, 1, 1, 1, 1, 1);
    add_item(FUNC_PAGE, '0, '0, 1, 1, 0, 1, 1);
    add_item(FUNC_UNUSED, 48'h9000, 22'h9, 1, 1, 1, 1, 1);
    add_item(FUNC_FINISH, '0, '0, 0, 0, 0, 0, 0);
    wait_idle();
    // backup room used up by the quota: second candidate dropped
    apb_write(REG_SCAN_MODE, MODE_SLOW_INT);
    apb_write(REG_PAGE_QUOTA, 1);
    add_item(FUNC_START, '0, '0, 0, 0, 0, 0, 0);
    add_item(FUNC_PAGE, 48'ha000, 22'ha, 1, 1, 0, 1, 1);
    add_item(FUNC_PAGE, 48'hb000, 22'hb, 1, 1, 1, 0, 1);
    add_item(FUNC_PAGE, 48'hc000, 22'hc, 1, 1, 1, 0, 1);
    add_item(FUNC_FINISH, '0, '0, 0, 0, 0, 0, 0);
    wait_idle();
    // quota lowered below the count already found, no new start
    apb_write(REG_SCAN_MODE, MODE_SLOW_WR);
    apb_write(REG_PAGE_QUOTA, 0);
    add_item(FUNC_PAGE, 48'hd000, 22'hd, 1, 1, 0, 1, 1);
    add_item(FUNC_FINISH, '0, '0, 0, 0, 0, 0, 0);
    wait_idle();
    apb_write(REG_SCAN_MODE, MODE_CLEAR);
    add_item(FUNC_PAGE, 48'he000, 22'he, 1, 1, 1, 1, 1);
    add_item(FUNC_FINISH, '0, '0, 0, 0, 0, 0, 0);
    wait_idle();
    apb_write(REG_SCAN_MODE, MODE_UNDEF);
    add_item(FUNC_PAGE, 48'hf000, 22'hf, 1, 1, 1, 1, 1);
    add_item(FUNC_FINISH, '0, '0, 0, 0, 0, 0, 0);

    // random scans: mostly start, pages, finish with a little noise
    while (rand_cnt < RAND_ITEMS) begin
      wait_idle();
      if ($urandom_range(0, 3) != 0)
        apb_write(REG_SCAN_MODE, ($urandom_range(0, 19) == 0) ? $urandom_range(5, 7)
                                                             : $urandom_range(0, 4));
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: apb_write(REG_PAGE_QUOTA, $urandom_range(1, 8));
          5, 6: apb_write(REG_PAGE_QUOTA, $urandom_range(0, 32));
          7: apb_write(REG_PAGE_QUOTA, 0);
          8: apb_write(REG_PAGE_QUOTA, 32);
          default: apb_write(REG_PAGE_QUOTA, $urandom_range(33, 63));
        endcase
      end
      if ($urandom_range(0, 5) != 0)
        add_item(FUNC_START, rand_addr(), rand_owner(), 1'($urandom), 1'($urandom),
                 1'($urandom), 1'($urandom), 1'($urandom));
      n = $urandom_range(1, 24);
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          f = 2'($urandom);
          if (f == FUNC_PAGE || f == FUNC_FINISH) rand_cnt++;
          add_item(f, rand_addr(), rand_owner(), 1'($urandom), 1'($urandom),
                   1'($urandom), 1'($urandom), 1'($urandom));
        end else begin
          ok = ($urandom_range(0, 4) != 0);
          add_item(FUNC_PAGE, rand_addr(), rand_owner(),
                   ok | 1'($urandom), ok | 1'($urandom), 1'($urandom), 1'($urandom),
                   ok | 1'($urandom));
          rand_cnt++;
        end
      end
      if ($urandom_range(0, 5) != 0) begin
        add_item(FUNC_FINISH, rand_addr(), rand_owner(), 1'($urandom), 1'($urandom),
                 1'($urandom), 1'($urandom), 1'($urandom));
        rand_cnt++;
      end
    end

    while (entry_q.size() != 0 || s_axis_tvalid || outcome_q.size() != 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatch_cnt == 0 && outcome_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ tiered_page_scan_selector_unit.f @@
sv/tpss_pkg.sv
sv/tpss_backup_mem.sv
sv/tpss_page_eval.sv
sv/tiered_page_scan_selector_unit.sv
verif/tiered_page_scan_selector_unit_test.sv
